// File: src/keyboard_scancode_decoder_macros.svh
// Assertion macros for the keyboard scan code decoder.
`ifndef KEYBOARD_SCANCODE_DECODER_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define KSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyboard decoder check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define KSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyboard decoder check failed");

`endif

// File: src/ksd_pkg.sv
// Package: keymap tables, scan code constants and queue types for the keyboard decoder.
`timescale 1ns / 1ps
`default_nettype none
package ksd_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LED_CMD = 8'hED;

  // Set-1 scan codes that carry meaning beyond the keymap
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_TAB       = 8'h0F;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_NUM       = 8'h45;
  localparam logic [7:0] SC_SCROLL    = 8'h46;
  localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
  localparam logic [7:0] SC_ACK       = 8'hFA;
  localparam logic [7:0] SC_RESEND    = 8'hFE;

  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  localparam logic [6:0] PLAIN_MAP [128] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h5e, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h40, 7'h5b, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3b,
    7'h3a, 7'h00, 7'h00, 7'h5d, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h5c, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5c, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_MAP [128] = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
    7'h27, 7'h28, 7'h29, 7'h7e, 7'h3d, 7'h7e, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h60, 7'h7b, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h2b,
    7'h2a, 7'h00, 7'h00, 7'h7d, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h5f, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7c, 7'h00, 7'h00
  };

  // Queue control from the decoder, status back from the queue
  typedef struct packed {
    logic       push_pair;  // enqueue LED_CMD then led_byte
    logic [7:0] led_byte;
    logic       pop;
  } ksd_qctl_t;

  typedef struct packed {
    logic       avail;      // a byte is there to pop, after this cycle's pushes
    logic [7:0] head_byte;
    logic       drop;       // push_pair did not fit completely
  } ksd_qsts_t;

endpackage
`default_nettype wire

// File: src/ksd_keymap.sv
// Scan code to ASCII lookup with shift and caps lock case folding.
`timescale 1ns / 1ps
`default_nettype none
module ksd_keymap
  import ksd_pkg::*;
(
  input  logic [6:0] code_i,
  input  logic       shifted_i,
  input  logic       caps_i,
  output logic [6:0] char_o
);

  logic [6:0] raw;

  assign raw = shifted_i ? SHIFT_MAP[code_i] : PLAIN_MAP[code_i];

  // letters fold to lowercase when caps and shift agree
  always_comb begin
    char_o = raw;
    if (raw >= 7'h41 && raw <= 7'h5a && caps_i == shifted_i) begin
      char_o = raw + 7'h20;
    end
  end

endmodule
`default_nettype wire

// File: src/ksd_cmd_queue.sv
// Keyboard command byte queue: pair push, single pop, same-cycle bypass.
`timescale 1ns / 1ps
`default_nettype none
module ksd_cmd_queue
  import ksd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ksd_qctl_t ctl_i,
  output ksd_qsts_t sts_o
);

  localparam logic [QCNT_W:0] DEPTH_W = (QCNT_W + 1)'(QUEUE_DEPTH);

  logic [7:0]        mem_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head_q, head_d;
  logic [QCNT_W-1:0] count_q, count_d, count_put;
  logic              fit1, fit2;
  logic [QIDX_W-1:0] wr_idx0, wr_idx1;

  function automatic logic [QIDX_W-1:0] wrap_idx(input logic [QCNT_W:0] s);
    logic [QCNT_W:0] r;
    r = (s >= DEPTH_W) ? s - DEPTH_W : s;
    return r[QIDX_W-1:0];
  endfunction

  assign fit1 = count_q < QCNT_W'(QUEUE_DEPTH);
  assign fit2 = count_q < QCNT_W'(QUEUE_DEPTH - 1);

  assign wr_idx0 = wrap_idx((QCNT_W + 1)'(head_q) + (QCNT_W + 1)'(count_q));
  assign wr_idx1 = wrap_idx((QCNT_W + 1)'(head_q) + (QCNT_W + 1)'(count_q) +
                            (QCNT_W + 1)'(1));

  always_comb begin
    count_put = count_q;
    if (ctl_i.push_pair) begin
      count_put = count_q + QCNT_W'(fit1) + QCNT_W'(fit2);
    end
    count_d = count_put - QCNT_W'(ctl_i.pop);
    head_d  = head_q;
    if (ctl_i.pop) begin
      head_d = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
    end
  end

  assign sts_o.avail = count_put != '0;
  assign sts_o.drop  = ctl_i.push_pair && !fit2;
  // empty queue: the head is the command byte pushed this cycle
  assign sts_o.head_byte = (count_q == '0) ? LED_CMD : mem_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= QCNT_W'(2);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        mem_q[i] <= '0;
      end
      mem_q[0] <= LED_CMD;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (ctl_i.push_pair && fit1) begin
        mem_q[wr_idx0] <= LED_CMD;
      end
      if (ctl_i.push_pair && fit2) begin
        mem_q[wr_idx1] <= ctl_i.led_byte;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/keyboard_scancode_decoder.sv
// Top level: set-1 scan code decoder with lock LED command queue.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata: scan_code, tuser: cmd
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: decoded result word
//  cfg      in   cfg_valid_i / cfg_ready_o      cfg_data_i: initial LED bits
//
// One request per cycle while m_axis_tready is high; input register, then
// result register, with the whole decode and state update in between.
// The input register frees as its request moves on, so a stalled result only
// stops intake once both registers are full.
// Reset: shift, focus and wait flag clear, LED bits zero, queue preloaded
// with the LED command byte and the LED bits.
// cfg_ready_o is always high; a write loads the LED state only.
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_scancode_decoder_macros.svh"
module keyboard_scancode_decoder
  import ksd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
  input  logic        s_axis_tuser,   // [0] cmd: 1 = poll only
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] char_valid, [7:1] char_code, [8] backspace_key, [9] enter_key,
  // [10] focus_console, [11] focus_changed, [12] tx_valid, [20:13] tx_byte,
  // [23:21] led_bits, [24] queue_overflow, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // LED register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_code_q;
  logic       in_poll_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  // decoder state
  logic [1:0] shift_q, shift_d;
  logic [2:0] led_q, led_d;
  logic       focus_q, focus_d;
  logic       ack_q, ack_d;
  logic [7:0] pending_q, pending_d;

  logic       fire;
  logic       key;
  logic [6:0] map_char, ch;
  logic       bs, enter, fchg, resend, ack_mid, txv, ovf;
  logic [7:0] txb;
  logic [2:0] led_toggle;

  ksd_qctl_t qctl;
  ksd_qsts_t qsts;

  // request moves from input register to result register
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  assign key = !in_poll_q;

  ksd_keymap u_keymap (
    .code_i    (in_code_q[6:0]),
    .shifted_i (shift_q != 2'b00),
    .caps_i    (led_q[2]),
    .char_o    (map_char)
  );

  ksd_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qctl),
    .sts_o  (qsts)
  );

  always_comb begin
    ch    = (key && !in_code_q[7]) ? map_char : 7'h00;
    bs    = key && in_code_q == SC_BACKSPACE;
    enter = key && in_code_q == SC_ENTER && focus_q;
    fchg  = key && in_code_q == SC_TAB;

    focus_d = fire ? focus_q ^ fchg : focus_q;

    shift_d = shift_q;
    if (fire && key) begin
      unique case (in_code_q)
        SC_LSHIFT:    shift_d = shift_q | 2'b01;
        SC_RSHIFT:    shift_d = shift_q | 2'b10;
        SC_LSHIFT_BR: shift_d = shift_q & 2'b10;
        SC_RSHIFT_BR: shift_d = shift_q & 2'b01;
        default:      shift_d = shift_q;
      endcase
    end

    led_toggle = 3'b000;
    if (key) begin
      unique case (in_code_q)
        SC_CAPS:   led_toggle = LED_CAPS;
        SC_NUM:    led_toggle = LED_NUM;
        SC_SCROLL: led_toggle = LED_SCROLL;
        default:   led_toggle = 3'b000;
      endcase
    end
    led_d = led_q ^ led_toggle;

    qctl.push_pair = fire && led_toggle != 3'b000;
    qctl.led_byte  = {5'b00000, led_d};
    ovf            = qctl.push_pair && qsts.drop;

    // acknowledge clears the wait first, so the next byte may go out now
    ack_mid   = (key && in_code_q == SC_ACK) ? 1'b0 : ack_q;
    resend    = key && in_code_q == SC_RESEND && ack_q;
    qctl.pop  = fire && !ack_mid && qsts.avail;
    ack_d     = fire ? (ack_mid || qctl.pop) : ack_q;
    pending_d = qctl.pop ? qsts.head_byte : pending_q;

    txv = resend || qctl.pop;
    txb = 8'h00;
    if (qctl.pop) begin
      txb = qsts.head_byte;
    end else if (resend) begin
      txb = pending_q;
    end

    out_data_d = {7'b0000000, ovf, led_d, txb, txv, fchg, focus_q ^ fchg,
                  enter, bs, ch, ch != 7'h00};
    out_valid_d = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= 2'b00;
      led_q       <= 3'b000;
      focus_q     <= 1'b0;
      ack_q       <= 1'b0;
      pending_q   <= 8'h00;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      shift_q     <= shift_d;
      focus_q     <= focus_d;
      ack_q       <= ack_d;
      pending_q   <= pending_d;
      if (cfg_valid_i) begin
        led_q <= cfg_data_i;
      end else if (fire) begin
        led_q <= led_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_code_q <= s_axis_tdata;
      in_poll_q <= s_axis_tuser;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  // any byte sent leaves an acknowledge outstanding
  `KSD_ASSERT_NEXT(a_tx_sets_wait, fire && txv, ack_q)
  // intake stops only with both registers full and the output stalled
  `KSD_ASSERT_SAME(a_stall_only_when_full, !s_axis_tready,
                   in_valid_q && out_valid_q && !m_axis_tready)
  // TAB flips focus
  `KSD_ASSERT_NEXT(a_tab_flips_focus, fire && fchg, focus_q != $past(focus_q))

endmodule
`default_nettype wire
